// File: src/bdpc_pkg.sv
// Shared types and constants for the button debounce and press classifier.
// No dependencies.
`timescale 1ns / 1ps
package bdpc_pkg;

  localparam int unsigned BUTTONS_DEFAULT  = 16;
  localparam int unsigned DEBOUNCE_DEFAULT = 2;

  localparam int unsigned IDX_W   = 4;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned BCNT_W  = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT  = 2'd1;

  localparam logic [TIME_W-1:0] LONG_PRESS_RESET   = 32'd1000;
  localparam logic [BCNT_W-1:0] BUTTON_COUNT_RESET = 5'd16;

  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  typedef struct packed {
    logic              cand;
    logic [CNT_W-1:0]  cnt;
    logic              stab;
    logic [TIME_W-1:0] start;
    logic              ld;
  } bdpc_entry_t;

  typedef struct packed {
    logic fire;
    logic kind;
  } bdpc_event_t;

endpackage

// File: src/bdpc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bdpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/bdpc_update.sv
// Per-button debounce and press classification update for one sample.
// Depends on bdpc_pkg.
`timescale 1ns / 1ps
module bdpc_update #(
  parameter int unsigned DEBOUNCE_COUNT = bdpc_pkg::DEBOUNCE_DEFAULT
) (
  input  bdpc_pkg::bdpc_entry_t          cur,
  input  logic                           pressed,
  input  logic [bdpc_pkg::TIME_W-1:0]    now_ms,
  input  logic [bdpc_pkg::TIME_W-1:0]    long_press_ms,
  output bdpc_pkg::bdpc_entry_t          nxt,
  output bdpc_pkg::bdpc_event_t          ev
);
  import bdpc_pkg::*;

  localparam logic [CNT_W-1:0] DB = CNT_W'(DEBOUNCE_COUNT);

  bdpc_entry_t       e;
  logic [TIME_W-1:0] held;

  always_comb begin
    e        = cur;
    ev.fire  = 1'b0;
    ev.kind  = KIND_SHORT;
    if (pressed == e.cand) begin
      if (e.cnt < DB) begin
        e.cnt = e.cnt + CNT_W'(1);
      end
    end else begin
      e.cand = pressed;
      e.cnt  = CNT_W'(1);
    end
    if (e.cnt >= DB && e.cand != e.stab) begin
      e.stab = e.cand;
      if (e.stab) begin
        e.start = now_ms;
        e.ld    = 1'b0;
      end else if (!e.ld) begin
        ev.fire = 1'b1;
        ev.kind = KIND_SHORT;
      end
    end
    held = now_ms - e.start;
    if (e.stab && !e.ld && held >= long_press_ms) begin
      ev.fire = 1'b1;
      ev.kind = KIND_LONG;
      e.ld    = 1'b1;
    end
    nxt = e;
  end

endmodule

// File: src/button_debounce_press_classifier.sv
// Button debouncer and short/long press classifier, top level.
// An accepted sample passes the update stage register, then the output event register.
// Throughput: one sample per cycle unless stalled, from RAM read and write-back forwarding.
// A stalled output holds the update stage and so holds the input.
// Reset clears valid flags, config and per-button valid bits at once; no clearing pass.
// Depends on bdpc_pkg, bdpc_ram, bdpc_update.
`timescale 1ns / 1ps
module button_debounce_press_classifier #(
  parameter int unsigned BUTTONS        = bdpc_pkg::BUTTONS_DEFAULT,
  parameter int unsigned DEBOUNCE_COUNT = bdpc_pkg::DEBOUNCE_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bdpc_pkg::IDX_W-1:0]        button_index,
  input  logic                              raw_level,
  input  logic [bdpc_pkg::TIME_W-1:0]       now_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bdpc_pkg::IDX_W-1:0]        event_button,
  output logic                              press_kind,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bdpc_pkg::*;

  localparam int unsigned AW  = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int unsigned CW  = 7;
  localparam int unsigned EW  = $bits(bdpc_entry_t);
  localparam logic [CW-1:0] NB = CW'(BUTTONS);

  logic [TIME_W-1:0] long_press_ms;
  logic [BCNT_W-1:0] button_count;

  logic              s1_valid;
  logic              s1_use;
  logic [IDX_W-1:0]  s1_idx;
  logic [AW-1:0]     s1_addr;
  logic              s1_pressed;
  logic [TIME_W-1:0] s1_now;
  logic              s1_adv;

  logic              fwd_valid;
  logic [AW-1:0]     fwd_addr;
  bdpc_entry_t       fwd_data;

  logic [BUTTONS-1:0] vld;

  logic              in_acc;
  logic [CW-1:0]     idx_ext;
  logic [AW-1:0]     in_addr;
  logic              in_use;
  logic [EW-1:0]     rdata;
  bdpc_entry_t       cur;
  bdpc_entry_t       nxt;
  bdpc_event_t       ev;
  logic              ram_we;
  logic              out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= LONG_PRESS_RESET;
      button_count  <= BUTTON_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LONG_PRESS_MS: long_press_ms <= cfg_data;
        REG_BUTTON_COUNT:  button_count  <= cfg_data[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign idx_ext = CW'(button_index);
  assign in_addr = idx_ext[AW-1:0];
  assign in_use  = (idx_ext < CW'(button_count)) && (idx_ext < NB);

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_use     <= in_use;
      s1_idx     <= button_index;
      s1_addr    <= in_addr;
      s1_pressed <= !raw_level;
      s1_now     <= now_ms;
    end
  end

  bdpc_ram #(
    .WIDTH (EW),
    .DEPTH (BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (nxt),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (rdata)
  );

  always_comb begin
    priority if (fwd_valid && fwd_addr == s1_addr) begin
      cur = fwd_data;
    end else if (vld[s1_addr]) begin
      cur = bdpc_entry_t'(rdata);
    end else begin
      cur = '0;
    end
  end

  bdpc_update #(
    .DEBOUNCE_COUNT (DEBOUNCE_COUNT)
  ) u_update (
    .cur           (cur),
    .pressed       (s1_pressed),
    .now_ms        (s1_now),
    .long_press_ms (long_press_ms),
    .nxt           (nxt),
    .ev            (ev)
  );

  assign ram_we   = s1_valid && s1_use && s1_adv;
  assign out_load = ram_we && ev.fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      vld       <= '0;
    end else if (ram_we) begin
      fwd_valid     <= 1'b1;
      vld[s1_addr]  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr <= s1_addr;
      fwd_data <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      event_button <= s1_idx;
      press_kind   <= ev.kind;
    end
  end

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_addr))
    else $error("update stage lost a held transaction");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted transaction missing from update stage");

  a_event_writes: assert property (@(posedge clk) disable iff (rst)
    out_load |-> ram_we && s1_use)
    else $error("event without state write-back");

  a_long_marks: assert property (@(posedge clk) disable iff (rst)
    out_load && ev.kind == KIND_LONG |-> nxt.stab && nxt.ld)
    else $error("long press without held, fired state");

  a_fwd_written: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> fwd_valid && vld[fwd_addr])
    else $error("forwarded entry not marked valid");

endmodule
